// ===== rtl/bpc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the banded palette colorizer.
package bpc_pkg;

   // Fixed field widths
   localparam int COUNT_W       = 24;
   localparam int MAX_ITER_W    = 16;
   localparam int BAND_W        = 24;
   localparam int PAL_COUNT_W   = 3;
   localparam int COLOR_W       = 24;
   localparam int CHAN_W        = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 24;

   // Design constants
   localparam int PALETTE_MAX   = 5;
   localparam int PALETTE_REGS  = 5;
   localparam int FRACTION_BITS = 8;
   localparam int BLEND_BITS    = 8;

   // One quotient bit per divider stage: count bits, then blend bits
   localparam int DIV_STEPS     = COUNT_W + BLEND_BITS;

   localparam int IDX_W         = $clog2(PALETTE_MAX);
   localparam int CNT_W         = $clog2(PALETTE_MAX + 1);
   localparam int PAL_IDX_W     = $clog2(PALETTE_REGS);
   localparam int LIMIT_W       = MAX_ITER_W + FRACTION_BITS;
   localparam int CMP_W         = (LIMIT_W > COUNT_W) ? LIMIT_W : COUNT_W;
   localparam int MIX_W         = CHAN_W + BLEND_BITS + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAL_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAL_COLOR_0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAL_COLOR_1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAL_COLOR_2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PAL_COLOR_3 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PAL_COLOR_4 = 3'd7;

   // Reset values
   localparam logic [MAX_ITER_W-1:0]  MAX_ITER_RST  = 16'd255;
   localparam logic [BAND_W-1:0]      BAND_RST      = 24'd2560;
   localparam logic [PAL_COUNT_W-1:0] PAL_COUNT_RST = 3'd5;
   localparam logic [CHAN_W-1:0]      BLACK_LEVEL   = 8'h00;

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [IDX_W:0]     mod_wide_type;

   // Divider pipeline beat
   typedef struct packed {
      logic                  valid;
      logic                  black;
      logic [COUNT_W-1:0]    dvd;    // dividend bits still to shift in
      logic [BAND_W-1:0]     rem;    // partial remainder
      logic [BLEND_BITS-1:0] frac;   // last quotient bits (blend)
      logic [IDX_W-1:0]      modv;   // earlier quotient bits modulo palette count
   } div_type;

   // Palette count as used: zero reads as one, large values saturate
   function automatic logic [CNT_W-1:0] clamp_count(input logic [PAL_COUNT_W-1:0] pc);
      logic [CNT_W-1:0] n;
      if (pc == '0) begin
         n = CNT_W'(1);
      end else if (32'(pc) > PALETTE_MAX) begin
         n = CNT_W'(PALETTE_MAX);
      end else begin
         n = CNT_W'(pc);
      end
      return n;
   endfunction

   // Zero band width divides as one
   function automatic logic [BAND_W-1:0] clamp_band(input logic [BAND_W-1:0] bw);
      return (bw == '0) ? BAND_W'(1) : bw;
   endfunction

   // Shift one quotient bit into a running residue modulo n (m < n)
   function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] m,
                                                  input logic b,
                                                  input logic [CNT_W-1:0] n);
      mod_wide_type t;
      mod_wide_type nw;
      t  = {m, b};
      nw = mod_wide_type'(n);
      if (t >= nw) begin
         t = t - nw;
      end
      return t[IDX_W-1:0];
   endfunction

   // Linear blend of one channel, truncated
   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] c0,
                                                      input logic [CHAN_W-1:0] c1,
                                                      input logic [BLEND_BITS-1:0] b);
      logic [BLEND_BITS:0] w0;
      logic [MIX_W-1:0]    acc;
      w0  = (BLEND_BITS+1)'(1 << BLEND_BITS) - (BLEND_BITS+1)'(b);
      acc = MIX_W'(w0) * MIX_W'(c0) + MIX_W'(b) * MIX_W'(c1);
      return acc[BLEND_BITS +: CHAN_W];
   endfunction

endpackage

// ===== rtl/bpc_div_stage.sv =====
// One radix-2 restoring division step with a pipeline register.
module bpc_div_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [bpc_pkg::BAND_W-1:0]    band,
   input  logic [bpc_pkg::CNT_W-1:0]     count_n,
   input  bpc_pkg::div_type              stage_i,
   output bpc_pkg::div_type              stage_o
);

   bpc_pkg::div_type              stage_ff;
   bpc_pkg::div_type              stage_in;
   logic [bpc_pkg::BAND_W:0]      trial;
   logic [bpc_pkg::BAND_W:0]      diff;
   logic                          qbit;

   // Shift next dividend bit into the remainder, subtract band if it fits
   always_comb begin
      trial = {stage_i.rem, stage_i.dvd[bpc_pkg::COUNT_W-1]};
      diff  = trial - (bpc_pkg::BAND_W+1)'(band);
      qbit  = (trial >= (bpc_pkg::BAND_W+1)'(band));

      stage_in       = stage_i;
      stage_in.dvd   = {stage_i.dvd[bpc_pkg::COUNT_W-2:0], 1'b0};
      stage_in.rem   = qbit ? diff[bpc_pkg::BAND_W-1:0] : trial[bpc_pkg::BAND_W-1:0];
      // Quotient bit enters the blend field; the bit leaving it feeds the residue
      stage_in.frac  = {stage_i.frac[bpc_pkg::BLEND_BITS-2:0], qbit};
      stage_in.modv  = bpc_pkg::mod_step(stage_i.modv,
                                         stage_i.frac[bpc_pkg::BLEND_BITS-1], count_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

// ===== rtl/bpc_mix.sv =====
// Palette lookup stage and per-channel blend into the result register.
module bpc_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [bpc_pkg::CNT_W-1:0]     count_n,
   input  bpc_pkg::color_type            palette [bpc_pkg::PALETTE_REGS],
   input  bpc_pkg::div_type              div_i,
   output logic                          sel_valid,
   output logic                          sel_black,
   output logic                          rsp_valid,
   output logic [bpc_pkg::CHAN_W-1:0]    rsp_red,
   output logic [bpc_pkg::CHAN_W-1:0]    rsp_green,
   output logic [bpc_pkg::CHAN_W-1:0]    rsp_blue
);

   localparam int CW = bpc_pkg::CHAN_W;

   bpc_pkg::color_type               next_color [bpc_pkg::PALETTE_REGS];
   logic [bpc_pkg::PAL_IDX_W-1:0]    pal_idx;

   logic                             sel_valid_ff;
   logic                             sel_black_ff;
   logic [bpc_pkg::BLEND_BITS-1:0]   sel_blend_ff;
   bpc_pkg::color_type               sel_c0_ff;
   bpc_pkg::color_type               sel_c1_ff;

   logic                             rsp_valid_ff;
   logic [CW-1:0]                    red_ff;
   logic [CW-1:0]                    green_ff;
   logic [CW-1:0]                    blue_ff;
   logic [CW-1:0]                    red_in;
   logic [CW-1:0]                    green_in;
   logic [CW-1:0]                    blue_in;

   // Successor entry of each palette slot, wrapping at the count in use
   for (genvar k = 0; k < bpc_pkg::PALETTE_REGS; k++) begin : g_next
      if (k < bpc_pkg::PALETTE_REGS - 1) begin : g_mid
         assign next_color[k] = (32'(count_n) > k + 1) ? palette[k+1] : palette[0];
      end else begin : g_last
         assign next_color[k] = palette[0];
      end
   end

   assign pal_idx = bpc_pkg::PAL_IDX_W'(div_i.modv);

   // Select stage: base and next colors
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (advance) begin
         sel_valid_ff <= div_i.valid;
         sel_black_ff <= div_i.black;
         sel_blend_ff <= div_i.frac;
         sel_c0_ff    <= palette[pal_idx];
         sel_c1_ff    <= next_color[pal_idx];
      end
   end

   // Blend stage
   always_comb begin
      if (sel_black_ff) begin
         red_in   = bpc_pkg::BLACK_LEVEL;
         green_in = bpc_pkg::BLACK_LEVEL;
         blue_in  = bpc_pkg::BLACK_LEVEL;
      end else begin
         red_in   = bpc_pkg::mix_channel(sel_c0_ff[2*CW +: CW], sel_c1_ff[2*CW +: CW],
                                         sel_blend_ff);
         green_in = bpc_pkg::mix_channel(sel_c0_ff[CW +: CW], sel_c1_ff[CW +: CW],
                                         sel_blend_ff);
         blue_in  = bpc_pkg::mix_channel(sel_c0_ff[0 +: CW], sel_c1_ff[0 +: CW],
                                         sel_blend_ff);
      end
   end

   // Result register; holds while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sel_valid_ff;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
      end
   end

   assign sel_valid = sel_valid_ff;
   assign sel_black = sel_black_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

// ===== rtl/banded_palette_colorizer.sv =====
// Top level of the banded palette colorizer: registers, divider chain, blend.
//
// Maps a pixel's smooth escape count (unsigned Q16.8) to an RGB color.
// Channels: req_ (valid/ready, iteration count in), rsp_ (valid/ready,
// red/green/blue out), csr_ (valid/ready register writes, always ready).
// A count equal to the iteration limit gives black; otherwise the count is
// divided by the band width, the quotient modulo the palette count picks a
// base entry and its wrapping successor, and the fraction blends the two.
// Throughput: one pixel per clock while the receiver does not stall. Each
// accepted beat passes 32 divider stages (one quotient bit each, 24 integer
// bits then 8 blend bits), one palette select stage and the result register.
// The divider's per-stage compare/subtract sets this depth. When the receiver
// stalls, the whole pipeline holds and req_ready drops; nothing is lost or
// repeated. Reset clears all pipeline valid bits and loads the register
// defaults: limit 255, band 2560, palette count 5, palette entries black. The
// user must write registers only while idle; the block does not enforce it.
module banded_palette_colorizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpc_pkg::COUNT_W-1:0]       req_iteration_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bpc_pkg::CHAN_W-1:0]        rsp_red,
   output logic [bpc_pkg::CHAN_W-1:0]        rsp_green,
   output logic [bpc_pkg::CHAN_W-1:0]        rsp_blue,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int STEPS = bpc_pkg::DIV_STEPS;

   logic [bpc_pkg::MAX_ITER_W-1:0]   max_iter_ff;
   logic [bpc_pkg::BAND_W-1:0]       band_width_ff;
   logic [bpc_pkg::PAL_COUNT_W-1:0]  pal_count_ff;
   bpc_pkg::color_type               palette_ff [bpc_pkg::PALETTE_REGS];

   logic [bpc_pkg::BAND_W-1:0]       band;
   logic [bpc_pkg::CNT_W-1:0]        count_n;
   logic [bpc_pkg::LIMIT_W-1:0]      limit;
   logic                             advance;
   logic                             sel_valid;
   logic                             sel_black;

   bpc_pkg::div_type                 chain [STEPS+1];
   logic [STEPS:1]                   chain_valid;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff   <= bpc_pkg::MAX_ITER_RST;
         band_width_ff <= bpc_pkg::BAND_RST;
         pal_count_ff  <= bpc_pkg::PAL_COUNT_RST;
         for (int k = 0; k < bpc_pkg::PALETTE_REGS; k++) begin
            palette_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bpc_pkg::REG_MAX_ITER:    max_iter_ff   <= csr_data[bpc_pkg::MAX_ITER_W-1:0];
            bpc_pkg::REG_BAND_WIDTH:  band_width_ff <= csr_data[bpc_pkg::BAND_W-1:0];
            bpc_pkg::REG_PAL_COUNT:   pal_count_ff  <= csr_data[bpc_pkg::PAL_COUNT_W-1:0];
            bpc_pkg::REG_PAL_COLOR_0: palette_ff[0] <= csr_data[bpc_pkg::COLOR_W-1:0];
            bpc_pkg::REG_PAL_COLOR_1: palette_ff[1] <= csr_data[bpc_pkg::COLOR_W-1:0];
            bpc_pkg::REG_PAL_COLOR_2: palette_ff[2] <= csr_data[bpc_pkg::COLOR_W-1:0];
            bpc_pkg::REG_PAL_COLOR_3: palette_ff[3] <= csr_data[bpc_pkg::COLOR_W-1:0];
            bpc_pkg::REG_PAL_COLOR_4: palette_ff[4] <= csr_data[bpc_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Effective settings
   assign band    = bpc_pkg::clamp_band(band_width_ff);
   assign count_n = bpc_pkg::clamp_count(pal_count_ff);
   assign limit   = {max_iter_ff, {bpc_pkg::FRACTION_BITS{1'b0}}};

   // Global stall: everything moves when the result register is free
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Entry beat
   always_comb begin
      chain[0].valid = req_valid;
      chain[0].black = (bpc_pkg::CMP_W'(req_iteration_count) == bpc_pkg::CMP_W'(limit));
      chain[0].dvd   = req_iteration_count;
      chain[0].rem   = '0;
      chain[0].frac  = '0;
      chain[0].modv  = '0;
   end

   // Divider chain
   for (genvar s = 0; s < STEPS; s++) begin : g_div
      bpc_div_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .band    (band),
         .count_n (count_n),
         .stage_i (chain[s]),
         .stage_o (chain[s+1])
      );
      assign chain_valid[s+1] = chain[s+1].valid;
   end

   bpc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .count_n   (count_n),
      .palette   (palette_ff),
      .div_i     (chain[STEPS]),
      .sel_valid (sel_valid),
      .sel_black (sel_black),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

   // A stalled pipeline keeps every beat in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain_valid) && $stable(sel_valid))
      else $error("pipeline moved during a stall");

   // Palette residue stays below the count in use
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      chain[STEPS].valid |-> (32'(chain[STEPS].modv) < 32'(count_n)))
      else $error("palette index out of range");

   // A pixel at the iteration limit comes out black
   a_black_out: assert property (@(posedge clock) disable iff (reset)
      sel_valid && sel_black && advance |=>
         rsp_valid && (rsp_red == bpc_pkg::BLACK_LEVEL) &&
         (rsp_green == bpc_pkg::BLACK_LEVEL) && (rsp_blue == bpc_pkg::BLACK_LEVEL))
      else $error("limit pixel not black");

endmodule

// ===== test/banded_palette_colorizer_tb.sv =====
// Self-checking testbench for the banded palette colorizer: directed and random pixels, checked per beat.
`timescale 1ns / 100ps

// Keeps a copy of the register file, predicts each pixel's color and checks results in order
class color_scoreboard;
   logic [bpc_pkg::MAX_ITER_W-1:0]  max_iter;
   logic [bpc_pkg::BAND_W-1:0]      band;
   logic [bpc_pkg::PAL_COUNT_W-1:0] pal_count;
   bpc_pkg::color_type              palette[bpc_pkg::PALETTE_REGS];
   bpc_pkg::color_type              expected_q[$];
   int                              errors;

   function new();
      int k;
      max_iter  = bpc_pkg::MAX_ITER_RST;
      band      = bpc_pkg::BAND_RST;
      pal_count = bpc_pkg::PAL_COUNT_RST;
      for (k = 0; k < bpc_pkg::PALETTE_REGS; k++) begin
         palette[k] = '0;
      end
      errors = 0;
   endfunction

   // Register write beat; narrow registers keep only their low bits
   function void note_write(input logic [bpc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bpc_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         bpc_pkg::REG_MAX_ITER: begin
            max_iter = data[bpc_pkg::MAX_ITER_W-1:0];
         end
         bpc_pkg::REG_BAND_WIDTH: begin
            band = data[bpc_pkg::BAND_W-1:0];
         end
         bpc_pkg::REG_PAL_COUNT: begin
            pal_count = data[bpc_pkg::PAL_COUNT_W-1:0];
         end
         default: begin
            palette[idx - bpc_pkg::REG_PAL_COLOR_0] = data[bpc_pkg::COLOR_W-1:0];
         end
      endcase
   endfunction

   // Color of one pixel under the current registers
   function bpc_pkg::color_type colorize(input logic [bpc_pkg::COUNT_W-1:0] count);
      logic [bpc_pkg::COUNT_W-1:0] limit;
      int unsigned        bw, n, quot, rest, blend, i0, i1, a, b, mix;
      bpc_pkg::color_type c0, c1, res;
      int                 k;
      limit = bpc_pkg::COUNT_W'(max_iter) << bpc_pkg::FRACTION_BITS;
      if (count == limit) begin
         return {3{bpc_pkg::BLACK_LEVEL}};
      end
      bw = (band == '0) ? 1 : band;
      if (pal_count == '0) begin
         n = 1;
      end else if (pal_count > bpc_pkg::PALETTE_MAX) begin
         n = bpc_pkg::PALETTE_MAX;
      end else begin
         n = 32'(pal_count);
      end
      quot  = count / bw;
      rest  = count % bw;
      blend = (rest << bpc_pkg::BLEND_BITS) / bw;
      i0    = quot % n;
      i1    = (i0 + 1) % n;
      c0    = palette[i0];
      c1    = palette[i1];
      // Per channel: weighted sum, truncated back to 8 bits
      for (k = 0; k < 3; k++) begin
         a   = 32'(c0[8*k +: 8]);
         b   = 32'(c1[8*k +: 8]);
         mix = (((1 << bpc_pkg::BLEND_BITS) - blend) * a + blend * b) >> bpc_pkg::BLEND_BITS;
         res[8*k +: 8] = mix[7:0];
      end
      return res;
   endfunction

   function void note_pixel(input logic [bpc_pkg::COUNT_W-1:0] count);
      expected_q.push_back(colorize(count));
   endfunction

   function void check_color(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      bpc_pkg::color_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected result beat: red %02h green %02h blue %02h", red, green, blue);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (red !== want[23:16]) begin
         $error("red mismatch: expected %02h, actual %02h", want[23:16], red);
         errors++;
      end
      if (green !== want[15:8]) begin
         $error("green mismatch: expected %02h, actual %02h", want[15:8], green);
         errors++;
      end
      if (blue !== want[7:0]) begin
         $error("blue mismatch: expected %02h, actual %02h", want[7:0], blue);
         errors++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module banded_palette_colorizer_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam logic [5*bpc_pkg::COLOR_W-1:0] PRIMARY_SET =
      {24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000};

   typedef enum {PAL_PRIMARIES, PAL_RANDOM, PAL_STRIPES} pal_mode_type;
   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [bpc_pkg::COUNT_W-1:0]    req_iteration_count;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [bpc_pkg::CHAN_W-1:0]     rsp_red;
   logic [bpc_pkg::CHAN_W-1:0]     rsp_green;
   logic [bpc_pkg::CHAN_W-1:0]     rsp_blue;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bpc_pkg::CSR_DATA_W-1:0] csr_data;

   color_scoreboard sb;
   int              cycles;
   int              burst_left;
   bit              steady;
   bit              hold_pending;

   banded_palette_colorizer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_iteration_count (req_iteration_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #1 clock = ~clock;

   // Observe every handshake at the edge where it completes; also the watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.note_write(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            sb.note_pixel(req_iteration_count);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_color(rsp_red, rsp_green, rsp_blue);
         end
      end
   end

   // Receiver: stall pattern picked at random among four modes; one long hold-off on request
   initial begin
      int          tick;
      rx_mode_type mode;
      rsp_ready = 1'b0;
      tick      = 0;
      mode      = RX_OPEN;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 100 == 0) begin
            mode = rx_mode_type'($urandom_range(0, 3));
         end
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= (tick % 4 == 0);
               default:   rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Sender idles in bursts: zero gap inside a burst, random gap between bursts
   function automatic int next_gap();
      if (steady) begin
         return 0;
      end
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 24);
      return $urandom_range(1, 8);
   endfunction

   // One pixel beat; valid stays up into the next beat when no gap follows
   task automatic send_pixel(input logic [bpc_pkg::COUNT_W-1:0] count);
      int gap;
      req_valid           <= 1'b1;
      req_iteration_count <= count;
      do @(posedge clock); while (!req_ready);
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [bpc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bpc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [bpc_pkg::CSR_DATA_W-1:0] iter_data,
                            input logic [bpc_pkg::CSR_DATA_W-1:0] band_data,
                            input logic [bpc_pkg::CSR_DATA_W-1:0] count_data,
                            input pal_mode_type pm);
      bpc_pkg::color_type shade;
      int                 k;
      write_reg(bpc_pkg::REG_MAX_ITER, iter_data);
      write_reg(bpc_pkg::REG_BAND_WIDTH, band_data);
      write_reg(bpc_pkg::REG_PAL_COUNT, count_data);
      for (k = 0; k < bpc_pkg::PALETTE_REGS; k++) begin
         case (pm)
            PAL_PRIMARIES: shade = PRIMARY_SET[bpc_pkg::COLOR_W*k +: bpc_pkg::COLOR_W];
            PAL_RANDOM:    shade = bpc_pkg::COLOR_W'($urandom());
            default:       shade = k[0] ? 24'h000000 : 24'hFFFFFF;
         endcase
         write_reg(bpc_pkg::CSR_IDX_W'(bpc_pkg::REG_PAL_COLOR_0 + k), shade);
      end
      csr_valid <= 1'b0;
   endtask

   // Drop valid and let every outstanding color come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [bpc_pkg::COUNT_W-1:0] limit_count();
      return bpc_pkg::COUNT_W'(sb.max_iter) << bpc_pkg::FRACTION_BITS;
   endfunction

   // Counts weighted toward the limit, band edges and the palette wrap
   function automatic logic [bpc_pkg::COUNT_W-1:0] pick_count();
      int unsigned bw, n, hi, pick;
      bw   = (sb.band == '0) ? 1 : sb.band;
      n    = (sb.pal_count == '0) ? 1 : sb.pal_count;
      hi   = bw * (n + 1);
      pick = $urandom_range(0, 99);
      if (hi > 24'hFFFFFF) begin
         hi = 24'hFFFFFF;
      end
      if (pick < 10) begin
         return limit_count();
      end else if (pick < 25) begin
         return bpc_pkg::COUNT_W'(bw * $urandom_range(0, 12));
      end else if (pick < 35) begin
         return ($urandom_range(0, 1) != 0) ? limit_count() + 1'b1 : limit_count() - 1'b1;
      end else if (pick < 70) begin
         return bpc_pkg::COUNT_W'($urandom_range(0, hi));
      end
      return bpc_pkg::COUNT_W'($urandom());
   endfunction

   task automatic run_random(input int items);
      int k;
      for (k = 0; k < items; k++) begin
         send_pixel(pick_count());
      end
   endtask

   task automatic run_phase(input logic [bpc_pkg::CSR_DATA_W-1:0] iter_data,
                            input logic [bpc_pkg::CSR_DATA_W-1:0] band_data,
                            input logic [bpc_pkg::CSR_DATA_W-1:0] count_data,
                            input pal_mode_type pm, input bit no_idle, input bit hold);
      wait_idle();
      configure(iter_data, band_data, count_data, pm);
      steady = no_idle;
      send_pixel(limit_count());
      send_pixel(24'hFFFFFF);
      hold_pending = hold;
      run_random(75);
      steady = 1'b0;
   endtask

   initial begin
      int bw;
      sb                  = new();
      cycles              = 0;
      burst_left          = 0;
      steady              = 1'b0;
      hold_pending        = 1'b0;
      clock               = 1'b0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_iteration_count = '0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Register defaults straight out of reset
      send_pixel(24'h000000);
      send_pixel(limit_count());
      run_random(20);

      // Directed: field extremes, limit edges, band edges, palette wrap
      wait_idle();
      configure(24'h0000FF, 24'd2560, 24'd5, PAL_PRIMARIES);
      bw = 32'(sb.band);
      send_pixel(24'h000000);
      send_pixel(24'h000001);
      send_pixel(24'hFFFFFF);
      send_pixel(limit_count());
      send_pixel(limit_count() - 1'b1);
      send_pixel(limit_count() + 1'b1);
      send_pixel(bpc_pkg::COUNT_W'(bw - 1));
      send_pixel(bpc_pkg::COUNT_W'(bw));
      send_pixel(bpc_pkg::COUNT_W'(3 * bw + bw / 2));
      send_pixel(bpc_pkg::COUNT_W'(5 * bw - 1));
      send_pixel(bpc_pkg::COUNT_W'(5 * bw));
      send_pixel(24'h800000);
      run_random(75);

      // Widest limit with upper junk masked, unit band, count saturating
      run_phase(24'hA5FFFF, 24'h000001, 24'h000007, PAL_RANDOM, 1'b0, 1'b1);
      // Zero limit, zero band, zero count, back to back with no idling
      run_phase(24'h000000, 24'h000000, 24'h000000, PAL_RANDOM, 1'b1, 1'b0);
      run_phase(24'h000001, 24'hFFFFFF, 24'h000006, PAL_STRIPES, 1'b0, 1'b0);
      run_phase(bpc_pkg::CSR_DATA_W'($urandom()),
                bpc_pkg::CSR_DATA_W'($urandom_range(1, 4096)),
                24'h000002, PAL_RANDOM, 1'b0, 1'b0);
      run_phase(bpc_pkg::CSR_DATA_W'($urandom()), bpc_pkg::CSR_DATA_W'($urandom()),
                24'hFFFFF3, PAL_RANDOM, 1'b0, 1'b0);
      run_phase(bpc_pkg::CSR_DATA_W'($urandom()),
                bpc_pkg::CSR_DATA_W'($urandom_range(256, 65535)),
                24'h000004, PAL_STRIPES, 1'b0, 1'b0);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/bpc_pkg.sv
rtl/bpc_div_stage.sv
rtl/bpc_mix.sv
rtl/banded_palette_colorizer.sv
test/banded_palette_colorizer_tb.sv
